// ===== hw/rtl/ebf_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped byte framer package
// Constants, payload types and the byte expansion function for the framer.
// ----------------------------------------------------------------------------
package ebf_pkg;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] END_TEXT    = 8'h03;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0] ESCAPE_FLIP = 8'h20;
  localparam logic [23:0] HINT_MAX   = 24'hFF_FFFF;

  localparam int RUN_MAX = 4;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [31:0] length_hint;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
  } run_t;

  // Turns one input word into the run of line bytes it causes; byte 0 goes first.
  function automatic run_t expand(input in_word_t w);
    run_t        r;
    logic [23:0] hint;
    r.bytes = '0;
    r.cnt   = '0;
    hint    = (|w.length_hint[31:24]) ? HINT_MAX : w.length_hint[23:0];
    case (w.action)
      ACT_START: begin
        r.bytes[0] = START_DELIM;
        r.bytes[1] = hint[23:16];
        r.bytes[2] = hint[15:8];
        r.bytes[3] = hint[7:0];
        r.cnt      = CNT_W'(4);
      end
      ACT_DATA: begin
        if (w.data_byte == START_DELIM || w.data_byte == END_TEXT ||
            w.data_byte == ESCAPE_BYTE) begin
          r.bytes[0] = ESCAPE_BYTE;
          r.bytes[1] = w.data_byte ^ ESCAPE_FLIP;
          r.cnt      = CNT_W'(2);
        end else begin
          r.bytes[0] = w.data_byte;
          r.cnt      = CNT_W'(1);
        end
      end
      ACT_END: begin
        r.bytes[0] = END_TEXT;
        r.cnt      = CNT_W'(1);
      end
      default: begin
        r.cnt = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/ebf_if.sv =====
// ----------------------------------------------------------------------------
// Escaped byte framer channels
// Valid/ready channels for the input words and the line bytes.
// ----------------------------------------------------------------------------
interface ebf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [31:0] length_hint;

  modport source (output valid, output action, output data_byte, output length_hint,
                  input ready);
  modport sink (input valid, input action, input data_byte, input length_hint,
                output ready);
endinterface

interface ebf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hw/rtl/escaped_byte_framer_top.sv =====
// ----------------------------------------------------------------------------
// Escaped byte framer
// Byte-stuffing frame builder with start, payload and end words.
// ----------------------------------------------------------------------------
// The input channel takes one word per handshake: a start word with a size
// hint, a payload byte or an end word. The output channel gives one line byte
// per handshake, with last_of_run set on the final byte caused by each word.
// A start word gives four bytes, an escaped payload byte two, any other
// payload byte or an end word one, and an unused action code none.
// An accepted word is held in an input register and expanded into a run
// register when that register is empty or its last byte leaves; its first
// byte is then offered from the run register. While the receiver is ready,
// the run register drains one byte per cycle and, if a word waits, is refilled
// in the same cycle as its last byte leaves, so single-byte words flow at one
// per cycle and for longer runs the sustained word rate is set by the run length.
// When the receiver stalls, the run register holds its bytes and the input
// register holds one further word, after which in_chan.ready falls.
// Reset is synchronous and active low; it empties both registers.
// ----------------------------------------------------------------------------
module escaped_byte_framer_top (
  input  logic      clk,
  input  logic      rst_n,
  ebf_in_if.sink    in_chan,
  ebf_out_if.source out_chan
);

  ebf_pkg::in_word_t                  in_r;
  logic                               in_vld_r;
  logic [ebf_pkg::RUN_MAX-1:0][7:0]   bytes_r;
  logic [ebf_pkg::CNT_W-1:0]          cnt_r;
  ebf_pkg::run_t                      run;
  logic                               pop;
  logic                               load;
  logic                               take;

  assign run  = ebf_pkg::expand(in_r);
  assign pop  = out_chan.valid && out_chan.ready;
  assign load = in_vld_r && ((cnt_r == '0) || (cnt_r == ebf_pkg::CNT_W'(1) && pop));
  assign take = in_chan.valid && in_chan.ready;

  assign in_chan.ready        = !in_vld_r || load;
  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.out_byte    = bytes_r[0];
  assign out_chan.last_of_run = (cnt_r == ebf_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r.action      <= in_chan.action;
      in_r.data_byte   <= in_chan.data_byte;
      in_r.length_hint <= in_chan.length_hint;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= run.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - ebf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= run.bytes;
    end else if (pop) begin
      for (int i = 0; i < ebf_pkg::RUN_MAX - 1; i++) begin
        bytes_r[i] <= bytes_r[i+1];
      end
      bytes_r[ebf_pkg::RUN_MAX-1] <= '0;
    end
  end

endmodule
